FILE: design/sharpen_edge_conv3x3_unit_defines.svh
// assertion macros for the sharpen edge conv3x3 unit
`ifndef SHARPEN_EDGE_CONV3X3_UNIT_DEFINES_SVH
`define SHARPEN_EDGE_CONV3X3_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SEC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SEC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SEC_ASSERT(lbl, prop, msg)
`define SEC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/sec_pkg.sv
// shared types and constants of the sharpen edge conv3x3 unit
package sec_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int LINE_AW    = $clog2(MAX_WIDTH);
	localparam int COL_W      = 11;
	localparam int ROW_W      = 16;
	localparam int FW_W       = 12;
	localparam int CH_W       = 8;
	localparam int CW_W       = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int LINE_W     = 2 * 3 * CH_W;

	localparam logic [FW_W-1:0]        FRAME_WIDTH_RST   = FW_W'(640);
	localparam logic [ROW_W-1:0]       FRAME_HEIGHT_RST  = ROW_W'(480);
	localparam logic signed [CW_W-1:0] CENTER_WEIGHT_RST = CW_W'(5);
	localparam logic [CH_W-1:0]        WHITE_THRESH_RST  = CH_W'(255);
	localparam logic signed [CW_W-1:0] EDGE_WEIGHT       = CW_W'(4);
	localparam logic [CH_W-1:0]        CH_MAX            = CH_W'(255);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH     = 2'd0,
		CFG_FRAME_HEIGHT    = 2'd1,
		CFG_CENTER_WEIGHT   = 2'd2,
		CFG_WHITE_THRESHOLD = 2'd3
	} cfg_idx_e;

	// [2] red, [1] green, [0] blue
	typedef logic [2:0][CH_W-1:0] px_t;

	// emit[0] pixel left above, emit[1] last column above, emit[2] current pixel
	typedef struct packed {
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
		logic [2:0]       emit;
		logic             border;
	} scan_t;

endpackage

FILE: design/sec_cfg_if.sv
// configuration write channel
interface sec_cfg_if;
	import sec_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/sec_pixel_if.sv
// input pixel channel
interface sec_pixel_if;
	import sec_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] in_red;
	logic [CH_W-1:0] in_green;
	logic [CH_W-1:0] in_blue;
	modport source (output valid, output in_red, output in_green, output in_blue, input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

FILE: design/sec_result_if.sv
// result pixel channel
interface sec_result_if;
	import sec_pkg::*;
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] out_col;
	logic [ROW_W-1:0] out_row;
	logic [CH_W-1:0]  out_red;
	logic [CH_W-1:0]  out_green;
	logic [CH_W-1:0]  out_blue;
	logic             run_last;
	modport source (output valid, output out_col, output out_row, output out_red,
		output out_green, output out_blue, output run_last, input ready);
	modport sink (input valid, input out_col, input out_row, input out_red,
		input out_green, input out_blue, input run_last, output ready);
endinterface

FILE: design/sec_ram.sv
// generic single write port ram with registered read
module sec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end
endmodule

FILE: design/sec_px_filter.sv
// cross kernel filter with clamp, white threshold and edge mode
module sec_px_filter (
	input  sec_pkg::px_t                    up,
	input  sec_pkg::px_t                    left,
	input  sec_pkg::px_t                    mid,
	input  sec_pkg::px_t                    right,
	input  sec_pkg::px_t                    down,
	input  logic signed [sec_pkg::CW_W-1:0] weight,
	input  logic [sec_pkg::CH_W-1:0]        threshold,
	output sec_pkg::px_t                    filtered
);
	import sec_pkg::*;

	localparam int ACC_W = 14;

	logic signed [ACC_W-1:0] acc [3];
	logic signed [ACC_W-1:0] w_ext;
	px_t                     clamped;
	logic [CH_W-1:0]         mx;

	always_comb begin
		w_ext = ACC_W'(weight);
		mx    = '0;
		for (int k = 0; k < 3; k++) begin
			acc[k] = w_ext * signed'({6'b0, mid[k]})
				- signed'({6'b0, up[k]}) - signed'({6'b0, down[k]})
				- signed'({6'b0, left[k]}) - signed'({6'b0, right[k]});
			if (acc[k] < 0) begin
				clamped[k] = '0;
			end else if (acc[k] > signed'({6'b0, CH_MAX})) begin
				clamped[k] = CH_MAX;
			end else begin
				clamped[k] = acc[k][CH_W-1:0];
			end
			if (clamped[k] > mx) begin
				mx = clamped[k];
			end
		end
		if (mx > threshold) begin
			filtered = {3{CH_MAX}};
		end else if (weight == EDGE_WEIGHT) begin
			filtered = '0;
		end else begin
			filtered = clamped;
		end
	end
endmodule

FILE: design/sec_scan_ctrl.sv
// column and row counters and result schedule
module sec_scan_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [sec_pkg::FW_W-1:0]   frame_width,
	input  logic [sec_pkg::ROW_W-1:0]  frame_height,
	output sec_pkg::scan_t             scan
);
	import sec_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [FW_W-1:0]  w_eff;
	logic [ROW_W-1:0] h_eff;
	logic             wrap_col;
	logic [ROW_W:0]   row_t;
	logic [COL_W-1:0] x;
	logic [ROW_W-1:0] y;
	logic [FW_W-1:0]  x_next;
	logic [ROW_W:0]   y_next;

	always_comb begin
		if (frame_width == '0) begin
			w_eff = FW_W'(1);
		end else if (frame_width > FW_W'(MAX_WIDTH)) begin
			w_eff = FW_W'(MAX_WIDTH);
		end else begin
			w_eff = frame_width;
		end
		h_eff    = (frame_height == '0) ? ROW_W'(1) : frame_height;
		wrap_col = {1'b0, col_q} >= w_eff;
		row_t    = wrap_col ? ({1'b0, row_q} + (ROW_W+1)'(1)) : {1'b0, row_q};
		y        = (row_t >= {1'b0, h_eff}) ? '0 : row_t[ROW_W-1:0];
		x        = wrap_col ? '0 : col_q;
		x_next   = {1'b0, x} + FW_W'(1);
		y_next   = {1'b0, y} + (ROW_W+1)'(1);

		scan.x       = x;
		scan.y       = y;
		scan.emit[0] = (y != '0) && (x != '0);
		scan.emit[1] = (y != '0) && ({1'b0, x} == w_eff - FW_W'(1));
		scan.emit[2] = (y == h_eff - ROW_W'(1));
		scan.border  = (x == COL_W'(1)) || (y == ROW_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (x_next >= w_eff) begin
				col_q <= '0;
				row_q <= (y_next >= {1'b0, h_eff}) ? '0 : y_next[ROW_W-1:0];
			end else begin
				col_q <= x_next[COL_W-1:0];
				row_q <= y;
			end
		end
	end
endmodule

FILE: design/sharpen_edge_conv3x3_unit.sv
// 3x3 cross kernel sharpen and edge filter over a raster rgb stream
// a taken pixel is held in stage s1, and each result it causes is registered into the result register
// throughput: one pixel per cycle while each pixel yields at most one result and result.ready does not stall the output
// a pixel yielding two or three results holds back the next pixel until all its results are sent (one result register)
// reset: counters and window cleared, registers to defaults, line stores keep their contents
`include "sharpen_edge_conv3x3_unit_defines.svh"
module sharpen_edge_conv3x3_unit (
	input  logic         clk,
	input  logic         arst_n,
	sec_cfg_if.sink      cfg,
	sec_pixel_if.sink    pixel,
	sec_result_if.source result
);
	import sec_pkg::*;

	logic [FW_W-1:0]        frame_width_q;
	logic [ROW_W-1:0]       frame_height_q;
	logic signed [CW_W-1:0] center_weight_q;
	logic [CH_W-1:0]        white_threshold_q;

	scan_t              scan;
	logic               in_acc;
	logic               valid_s1;
	scan_t              scan_s1;
	px_t                pix_s1;
	logic               fwd_s1;
	logic [LINE_W-1:0]  fwd_data_s1;
	logic [2:0]         sent_q;
	px_t                win_up_q;
	px_t                win_mid_q;
	px_t                win_down_q;
	px_t                win_left_q;
	logic [LINE_W-1:0]  ram_rd;
	px_t                a_eff;
	px_t                b_eff;
	px_t                filt;
	logic [2:0]         pend;
	logic [2:0]         sel;
	logic [2:0]         rest;
	logic               out_free;
	logic               fire;
	logic               retire;
	logic [COL_W-1:0]   res_col;
	logic [ROW_W-1:0]   res_row;
	px_t                res_px;
	logic               out_valid_q;
	logic               out_last_q;
	logic [COL_W-1:0]   out_col_q;
	logic [ROW_W-1:0]   out_row_q;
	px_t                out_px_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q     <= FRAME_WIDTH_RST;
			frame_height_q    <= FRAME_HEIGHT_RST;
			center_weight_q   <= CENTER_WEIGHT_RST;
			white_threshold_q <= WHITE_THRESH_RST;
		end else if (cfg.valid) begin
			case (cfg_idx_e'(cfg.index))
				CFG_FRAME_WIDTH:     frame_width_q     <= cfg.data[FW_W-1:0];
				CFG_FRAME_HEIGHT:    frame_height_q    <= cfg.data[ROW_W-1:0];
				CFG_CENTER_WEIGHT:   center_weight_q   <= signed'(cfg.data[CW_W-1:0]);
				CFG_WHITE_THRESHOLD: white_threshold_q <= cfg.data[CH_W-1:0];
				default: ;
			endcase
		end
	end

	sec_scan_ctrl u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (in_acc),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.scan         (scan)
	);

	// line stores: upper half row y-2, lower half row y-1
	sec_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk     (clk),
		.wr_en   (retire),
		.wr_addr (scan_s1.x[LINE_AW-1:0]),
		.wr_data ({b_eff, pix_s1}),
		.rd_en   (in_acc),
		.rd_addr (scan.x[LINE_AW-1:0]),
		.rd_data (ram_rd)
	);

	assign {a_eff, b_eff} = fwd_s1 ? fwd_data_s1 : ram_rd;

	sec_px_filter u_filter (
		.up        (win_up_q),
		.left      (win_left_q),
		.mid       (win_mid_q),
		.right     (b_eff),
		.down      (win_down_q),
		.weight    (center_weight_q),
		.threshold (white_threshold_q),
		.filtered  (filt)
	);

	// result sequencing
	always_comb begin
		pend = valid_s1 ? (scan_s1.emit & ~sent_q) : 3'b000;
		if (pend[0]) begin
			sel = 3'b001;
		end else if (pend[1]) begin
			sel = 3'b010;
		end else begin
			sel = pend & 3'b100;
		end
		rest     = pend & ~sel;
		out_free = !out_valid_q || result.ready;
		fire     = (pend != 3'b000) && out_free;
		retire   = valid_s1 && ((pend == 3'b000) || (fire && (rest == 3'b000)));

		if (sel[0]) begin
			res_col = scan_s1.x - COL_W'(1);
			res_row = scan_s1.y - ROW_W'(1);
			res_px  = scan_s1.border ? win_mid_q : filt;
		end else if (sel[1]) begin
			res_col = scan_s1.x;
			res_row = scan_s1.y - ROW_W'(1);
			res_px  = b_eff;
		end else begin
			res_col = scan_s1.x;
			res_row = scan_s1.y;
			res_px  = pix_s1;
		end
	end

	assign pixel.ready = !valid_s1 || retire;
	assign in_acc      = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			sent_q   <= 3'b000;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= retire && (scan.x == scan_s1.x);
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
			if (retire) begin
				sent_q <= 3'b000;
			end else if (fire) begin
				sent_q <= sent_q | sel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			scan_s1     <= scan;
			pix_s1      <= {pixel.in_red, pixel.in_green, pixel.in_blue};
			fwd_data_s1 <= {b_eff, pix_s1};
		end
	end

	// window columns x-1 and x-2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_up_q   <= '0;
			win_mid_q  <= '0;
			win_down_q <= '0;
			win_left_q <= '0;
		end else if (retire) begin
			win_up_q   <= a_eff;
			win_mid_q  <= b_eff;
			win_down_q <= pix_s1;
			win_left_q <= win_mid_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_col_q  <= res_col;
			out_row_q  <= res_row;
			out_px_q   <= res_px;
			out_last_q <= (rest == 3'b000);
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_col   = out_col_q;
	assign result.out_row   = out_row_q;
	assign result.out_red   = out_px_q[2];
	assign result.out_green = out_px_q[1];
	assign result.out_blue  = out_px_q[0];
	assign result.run_last  = out_last_q;

	`SEC_ASSERT(a_sent_subset, valid_s1 |-> ((sent_q & ~scan_s1.emit) == 3'b000), "sent mask beyond schedule")
	`SEC_ASSERT_NEXT(a_fwd_same_col, (retire && in_acc && (scan.x == scan_s1.x)), fwd_s1, "missing line forward")
	`SEC_ASSERT_NEXT(a_last_on_retire, (retire && (scan_s1.emit != 3'b000)), (out_valid_q && out_last_q), "retire without last result")
endmodule
